/* design/bdm_pkg.sv */
`timescale 1ns / 1ps
package bdm_pkg;
  localparam int PIX_W = 8;
  localparam int COL_W = 10;
  localparam int ROW_W = 13;
  localparam int HGT_W = 12;
  localparam int CFG_W = 12;
  localparam int TAPS = 5;
  localparam int LINE_W = 4 * PIX_W;
  localparam int SUM_W = 15;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;
  localparam logic [COL_W-1:0] MIN_WIDTH = 10'd5;
  localparam logic [HGT_W-1:0] MIN_HEIGHT = 12'd5;
  localparam int RESET_WIDTH = 390;
  localparam logic [HGT_W-1:0] RESET_HEIGHT = 12'd300;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [TAPS-1:0] col_t;
  typedef col_t [TAPS-1:0] win_t;

  typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;
  typedef enum logic [1:0] {EV_REAL, EV_VIRT1, EV_VIRT2} ev_kind_t;
  typedef enum logic [2:0] {VS_NORM, VS_TOP0, VS_TOP1, VS_BOT0, VS_BOT1} vsel_t;
  typedef enum logic [1:0] {XS_MID, XS_LEFT0, XS_LEFT1} xsel_t;

  typedef struct packed {
    xsel_t xsel;
    logic  odd_row;
    logic  odd_col;
    logic  eor;
    logic  eof;
  } tag_t;

  typedef struct packed {
    pix_t       c;
    logic [8:0] h1;
    logic [8:0] h2;
    logic [8:0] v1;
    logic [8:0] v2;
    logic [9:0] dg;
  } sums_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic end_of_row;
    logic end_of_frame;
  } rgb_t;
endpackage

/* design/bdm_line_mem.sv */
`timescale 1ns / 1ps
module bdm_line_mem #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [bdm_pkg::LINE_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bdm_pkg::LINE_W-1:0] wr_data
);
  import bdm_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* design/bdm_cell.sv */
`timescale 1ns / 1ps
module bdm_cell (
  input  logic          clk,
  input  logic          shift,
  input  bdm_pkg::col_t din,
  output bdm_pkg::col_t dout
);
  import bdm_pkg::*;

  col_t column;

  always_ff @(posedge clk) begin
    if (shift) begin
      column <= din;
    end
  end

  assign dout = column;
endmodule

/* design/bdm_kernel.sv */
`timescale 1ns / 1ps
module bdm_kernel (
  input  logic          clk,
  input  logic          rst,
  input  logic          tag_valid,
  input  bdm_pkg::tag_t tag_in,
  input  bdm_pkg::win_t window,
  output logic          rgb_valid,
  output bdm_pkg::rgb_t rgb,
  output logic [1:0]    inflight
);
  import bdm_pkg::*;

  function automatic pix_t round_clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    begin
      t = s + 15'sd8;
      if (t < 15'sd0) begin
        return 8'd0;
      end else if (t > 15'sd4095) begin
        return 8'd255;
      end
      return t[11:4];
    end
  endfunction

  logic  a_valid;
  tag_t  a_tag;
  logic  b_valid;
  tag_t  b_tag;
  sums_t b_sums;
  win_t  hw;
  sums_t sums_next;
  rgb_t  rgb_next;

  logic signed [SUM_W-1:0] sc, sh1, sh2, sv1, sv2, sdg;
  logic signed [SUM_W-1:0] g_rb, horiz, vert, diag;

  // horizontal mirror at the left edge
  always_comb begin
    case (a_tag.xsel)
      XS_LEFT0: begin
        hw[0] = window[4];
        hw[1] = window[3];
        hw[2] = window[2];
        hw[3] = window[3];
        hw[4] = window[4];
      end
      XS_LEFT1: begin
        hw[0] = window[2];
        hw[1] = window[1];
        hw[2] = window[2];
        hw[3] = window[3];
        hw[4] = window[4];
      end
      default: begin
        hw = window;
      end
    endcase
  end

  always_comb begin
    sums_next.c  = hw[2][2];
    sums_next.h1 = {1'b0, hw[1][2]} + {1'b0, hw[3][2]};
    sums_next.h2 = {1'b0, hw[0][2]} + {1'b0, hw[4][2]};
    sums_next.v1 = {1'b0, hw[2][1]} + {1'b0, hw[2][3]};
    sums_next.v2 = {1'b0, hw[2][0]} + {1'b0, hw[2][4]};
    sums_next.dg = {2'b0, hw[1][1]} + {2'b0, hw[3][1]} + {2'b0, hw[1][3]} + {2'b0, hw[3][3]};
  end

  always_comb begin
    sc  = $signed({7'b0, b_sums.c});
    sh1 = $signed({6'b0, b_sums.h1});
    sh2 = $signed({6'b0, b_sums.h2});
    sv1 = $signed({6'b0, b_sums.v1});
    sv2 = $signed({6'b0, b_sums.v2});
    sdg = $signed({5'b0, b_sums.dg});
    g_rb  = 15'sd8 * sc + 15'sd4 * (sh1 + sv1) - 15'sd2 * (sh2 + sv2);
    horiz = 15'sd10 * sc + 15'sd8 * sh1 - 15'sd2 * sh2 - 15'sd2 * sdg + sv2;
    vert  = 15'sd10 * sc + 15'sd8 * sv1 - 15'sd2 * sv2 - 15'sd2 * sdg + sh2;
    diag  = 15'sd12 * sc + 15'sd4 * sdg - 15'sd3 * (sh2 + sv2);
  end

  always_comb begin
    rgb_next.end_of_row   = b_tag.eor;
    rgb_next.end_of_frame = b_tag.eof;
    case ({b_tag.odd_row, b_tag.odd_col})
      2'b00: begin
        rgb_next.green = b_sums.c;
        rgb_next.red   = round_clamp(horiz);
        rgb_next.blue  = round_clamp(vert);
      end
      2'b11: begin
        rgb_next.green = b_sums.c;
        rgb_next.red   = round_clamp(vert);
        rgb_next.blue  = round_clamp(horiz);
      end
      2'b01: begin
        rgb_next.red   = b_sums.c;
        rgb_next.green = round_clamp(g_rb);
        rgb_next.blue  = round_clamp(diag);
      end
      default: begin
        rgb_next.blue  = b_sums.c;
        rgb_next.green = round_clamp(g_rb);
        rgb_next.red   = round_clamp(diag);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      a_valid   <= tag_valid;
      b_valid   <= a_valid;
      rgb_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_tag  <= tag_in;
    b_tag  <= a_tag;
    b_sums <= sums_next;
    rgb    <= rgb_next;
  end

  assign inflight = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, rgb_valid};
endmodule

/* design/bdm_out_fifo.sv */
`timescale 1ns / 1ps
module bdm_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bdm_pkg::rgb_t               din,
  input  logic                        pop,
  output bdm_pkg::rgb_t               dout,
  output logic                        not_empty,
  output logic [bdm_pkg::FIFO_CW-1:0] count
);
  import bdm_pkg::*;

  rgb_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign dout      = entries[rd_ptr];
  assign not_empty = (count != '0);
endmodule

/* design/bayer_demosaic_5x5.sv */
`timescale 1ns / 1ps
// GRBG Bayer to RGB demosaic with the 5x5 Malvar-He-Cutler kernels and mirrored borders.
// One sample is accepted per clock while the output queue has room; after the last column
// of each row from the third row on, the input pauses while the two right-edge pixels are
// formed by feeding mirrored columns back into the five-cell column chain. Output pixels
// trail their input by two rows and two columns and leave a pipeline (line memory read,
// column chain, two kernel stages) through an 8-entry output queue, so a stalled consumer
// does not stop input until queued and in-flight pixels fill the queue's eight entries.
// The line memory is one read and one write port of four packed rows and needs no
// clearing pass. Width and height are sampled at the first pixel of each frame. After
// the frame, 2*width transactions with flush set drain the last two output rows; a
// flush transaction before then is taken and ignored.
module bayer_demosaic_5x5 #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  bdm_pkg::reg_idx_t         cfg_index,
  input  logic [bdm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                raw_pixel,
  input  logic                      flush,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      end_of_row,
  output logic                      end_of_frame
);
  import bdm_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WMAX_I = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam logic [COL_W-1:0] WMAX = COL_W'(WMAX_I);
  localparam logic [COL_W-1:0] RST_W = COL_W'((RESET_WIDTH < WMAX_I) ? RESET_WIDTH : WMAX_I);

  logic [COL_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [COL_W-1:0] frame_w;
  logic [HGT_W-1:0] frame_h;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [1:0]       pend;
  logic             pend_odd;
  logic             pend_last;
  logic             pend_wodd;

  logic [COL_W-1:0] sat_w, cur_w;
  logic [HGT_W-1:0] sat_h, cur_h;
  logic [ROW_W-1:0] h_ext, row_inc;
  logic             start, live, drop, take, last_col, past_top, emit_real, virt_issue;
  logic             credit_ok;
  vsel_t            vsel_next;
  xsel_t            xsel_next;
  logic [AW+COL_W-1:0] col_wide;
  logic [AW-1:0]    addr_next;

  logic             s1_valid;
  logic             s1_emit;
  ev_kind_t         s1_kind;
  pix_t             s1_pixel;
  logic [AW-1:0]    s1_addr;
  logic             s1_wr;
  vsel_t            s1_vsel;
  tag_t             s1_tag;

  logic [LINE_W-1:0] rd_data;
  col_t              tp;
  col_t              col_in;
  win_t              win;

  logic              k_valid;
  rgb_t              k_rgb;
  logic [1:0]        k_inflight;
  rgb_t              q_rgb;
  logic [FIFO_CW-1:0] q_count;
  logic [FIFO_CW:0]  pending_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= COL_W'(RESET_WIDTH);
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[COL_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sat_w = image_width;
    if (image_width < MIN_WIDTH) begin
      sat_w = MIN_WIDTH;
    end else if (image_width > WMAX) begin
      sat_w = WMAX;
    end
    sat_h = (image_height < MIN_HEIGHT) ? MIN_HEIGHT : image_height;
  end

  assign start     = (row == '0) && (col == '0);
  assign cur_w     = start ? sat_w : frame_w;
  assign cur_h     = start ? sat_h : frame_h;
  assign h_ext     = {1'b0, cur_h};
  assign live      = row < h_ext;
  assign drop      = flush && live;
  assign last_col  = col == (cur_w - 10'd1);
  assign past_top  = row >= 13'd2;
  assign emit_real = past_top && (col >= 10'd2);
  assign row_inc   = row + 13'd1;

  assign pending_total = {1'b0, q_count} + FIFO_CW'(k_inflight) + FIFO_CW'(s1_emit);
  assign credit_ok     = pending_total < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign in_ready      = (pend == 2'd0) && credit_ok;
  assign take          = in_valid && in_ready && !drop;
  assign virt_issue    = (pend != 2'd0) && credit_ok;

  always_comb begin
    if (row == 13'd2) begin
      vsel_next = VS_TOP0;
    end else if (row == 13'd3) begin
      vsel_next = VS_TOP1;
    end else if (row == h_ext) begin
      vsel_next = VS_BOT0;
    end else if (row == h_ext + 13'd1) begin
      vsel_next = VS_BOT1;
    end else begin
      vsel_next = VS_NORM;
    end
    if (col == 10'd2) begin
      xsel_next = XS_LEFT0;
    end else if (col == 10'd3) begin
      xsel_next = XS_LEFT1;
    end else begin
      xsel_next = XS_MID;
    end
  end

  assign col_wide  = {{AW{1'b0}}, col};
  assign addr_next = col_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      frame_w <= RST_W;
      frame_h <= RESET_HEIGHT;
      pend    <= 2'd0;
    end else begin
      if (take) begin
        if (start) begin
          frame_w <= sat_w;
          frame_h <= sat_h;
        end
        if (last_col) begin
          col <= '0;
          row <= (row_inc >= h_ext + 13'd2) ? '0 : row_inc;
        end else begin
          col <= col + 10'd1;
        end
      end
      if (take && past_top && last_col) begin
        pend <= 2'd2;
      end else if (virt_issue) begin
        pend <= pend - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_odd  <= row[0];
      pend_last <= row == h_ext + 13'd1;
      pend_wodd <= cur_w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= take || virt_issue;
      s1_emit  <= (take && emit_real) || virt_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind         <= EV_REAL;
      s1_pixel        <= raw_pixel;
      s1_addr         <= addr_next;
      s1_wr           <= live;
      s1_vsel         <= vsel_next;
      s1_tag.xsel     <= xsel_next;
      s1_tag.odd_row  <= row[0];
      s1_tag.odd_col  <= col[0];
      s1_tag.eor      <= 1'b0;
      s1_tag.eof      <= 1'b0;
    end else if (virt_issue) begin
      s1_kind         <= (pend == 2'd2) ? EV_VIRT1 : EV_VIRT2;
      s1_wr           <= 1'b0;
      s1_tag.xsel     <= XS_MID;
      s1_tag.odd_row  <= pend_odd;
      s1_tag.odd_col  <= (pend == 2'd2) ? pend_wodd : !pend_wodd;
      s1_tag.eor      <= pend == 2'd1;
      s1_tag.eof      <= (pend == 2'd1) && pend_last;
    end
  end

  bdm_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (addr_next),
    .rd_data (rd_data),
    .wr_en   (s1_valid && (s1_kind == EV_REAL) && s1_wr),
    .wr_addr (s1_addr),
    .wr_data ({rd_data[3*PIX_W-1:0], s1_pixel})
  );

  // taps hold rows r-4 .. r at the current column
  assign tp[0] = rd_data[4*PIX_W-1:3*PIX_W];
  assign tp[1] = rd_data[3*PIX_W-1:2*PIX_W];
  assign tp[2] = rd_data[2*PIX_W-1:PIX_W];
  assign tp[3] = rd_data[PIX_W-1:0];
  assign tp[4] = s1_pixel;

  always_comb begin
    case (s1_kind)
      EV_VIRT1: col_in = win[3];
      EV_VIRT2: col_in = win[1];
      default: begin
        case (s1_vsel)
          VS_TOP0: col_in = {tp[4], tp[3], tp[2], tp[3], tp[4]};
          VS_TOP1: col_in = {tp[4], tp[3], tp[2], tp[1], tp[2]};
          VS_BOT0: col_in = {tp[2], tp[3], tp[2], tp[1], tp[0]};
          VS_BOT1: col_in = {tp[1], tp[2], tp[3], tp[2], tp[1]};
          default: col_in = tp;
        endcase
      end
    endcase
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_chain
    if (k == TAPS - 1) begin : g_head
      bdm_cell u_cell (
        .clk   (clk),
        .shift (s1_valid),
        .din   (col_in),
        .dout  (win[k])
      );
    end else begin : g_body
      bdm_cell u_cell (
        .clk   (clk),
        .shift (s1_valid),
        .din   (win[k+1]),
        .dout  (win[k])
      );
    end
  end

  bdm_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .tag_valid (s1_valid && s1_emit),
    .tag_in    (s1_tag),
    .window    (win),
    .rgb_valid (k_valid),
    .rgb       (k_rgb),
    .inflight  (k_inflight)
  );

  bdm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (k_valid),
    .din       (k_rgb),
    .pop       (out_valid && out_ready),
    .dout      (q_rgb),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign red          = q_rgb.red;
  assign green        = q_rgb.green;
  assign blue         = q_rgb.blue;
  assign end_of_row   = q_rgb.end_of_row;
  assign end_of_frame = q_rgb.end_of_frame;
endmodule

/* design/bdm_checker.sv */
`timescale 1ns / 1ps
module bdm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       flush,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       end_of_row,
  input logic       end_of_frame
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(flush))
    else $error("input transaction withdrawn while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue)
      && $stable(end_of_row) && $stable(end_of_frame))
    else $error("output transaction changed while stalled");

  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row)
    else $error("end of frame without end of row");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");
endmodule

bind bayer_demosaic_5x5 bdm_checker u_bdm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .flush        (flush),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .end_of_row   (end_of_row),
  .end_of_frame (end_of_frame)
);

/* test/bayer_demosaic_5x5_test.sv */
`timescale 1ns / 1ps
module bayer_demosaic_5x5_test;
  import bdm_pkg::*;

  localparam int LINE_MAX = 512;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [7:0] pix;
    logic       fl;
  } sample_t;

  logic             clk = 1'b1;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  reg_idx_t         cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       raw_pixel = '0;
  logic             flush = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       red, green, blue;
  logic             end_of_row, end_of_frame;

  sample_t    pending_samples[$];
  rgb_t       rgb_expected[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         errors = 0;
  int         quiet_cycles = 0;

  logic [9:0]  cfg_w_shadow = 10'd390;
  logic [11:0] cfg_h_shadow = 12'd300;
  logic [7:0]  line_mem[5][LINE_MAX];
  int          col_cnt = 0, row_cnt = 0, fw = 390, fh = 300;

  bayer_demosaic_5x5 dut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int sat_width(int v);
    if (v < 5) return 5;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  function automatic int sat_height(int v);
    if (v < 5) return 5;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int reflect(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * (n - 1) - i;
    return i;
  endfunction

  function automatic logic [7:0] round_clamp(int s);
    int t;
    t = s + 8;
    if (t < 0) return 8'd0;
    t = t / 16;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  task automatic emit_pixel(int o, int x);
    int   w[5][5];
    int   cc, h1, h2, v1, v2, dg, g_rb, horiz, vert, diag;
    rgb_t px;
    for (int dy = 0; dy < 5; dy++)
      for (int dx = 0; dx < 5; dx++)
        w[dy][dx] = line_mem[reflect(o + dy - 2, fh) % 5][reflect(x + dx - 2, fw)];
    cc = w[2][2];
    h1 = w[2][1] + w[2][3];
    h2 = w[2][0] + w[2][4];
    v1 = w[1][2] + w[3][2];
    v2 = w[0][2] + w[4][2];
    dg = w[1][1] + w[1][3] + w[3][1] + w[3][3];
    g_rb = 8 * cc + 4 * (h1 + v1) - 2 * (h2 + v2);
    horiz = 10 * cc + 8 * h1 - 2 * h2 - 2 * dg + v2;
    vert = 10 * cc + 8 * v1 - 2 * v2 - 2 * dg + h2;
    diag = 12 * cc + 4 * dg - 3 * (h2 + v2);
    if (o % 2 == 0 && x % 2 == 0) begin
      px.green = cc[7:0]; px.red = round_clamp(horiz); px.blue = round_clamp(vert);
    end else if (o % 2 == 1 && x % 2 == 1) begin
      px.green = cc[7:0]; px.red = round_clamp(vert); px.blue = round_clamp(horiz);
    end else if (o % 2 == 0) begin
      px.red = cc[7:0]; px.green = round_clamp(g_rb); px.blue = round_clamp(diag);
    end else begin
      px.blue = cc[7:0]; px.green = round_clamp(g_rb); px.red = round_clamp(diag);
    end
    px.end_of_row = (x == fw - 1);
    px.end_of_frame = (x == fw - 1) && (o == fh - 1);
    rgb_expected.push_back(px);
  endtask

  task automatic accept_sample(logic [7:0] pix, logic fl);
    int r, c;
    if (row_cnt == 0 && col_cnt == 0) begin
      if (fl) return;
      fw = sat_width(cfg_w_shadow);
      fh = sat_height(cfg_h_shadow);
    end
    r = row_cnt;
    c = col_cnt;
    if (r < fh) begin
      if (fl) return;
      line_mem[r % 5][c] = pix;
    end
    if (r >= 2) begin
      if (c >= 2 && c + 2 <= fw) begin
        emit_pixel(r - 2, c - 2);
      end else if (c == fw - 1) begin
        emit_pixel(r - 2, c - 2);
        emit_pixel(r - 2, c - 1);
        emit_pixel(r - 2, c);
      end
    end
    col_cnt = c + 1;
    if (col_cnt >= fw) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= fh + 2) row_cnt = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) accept_sample(raw_pixel, flush);
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        raw_pixel <= pending_samples[0].pix;
        flush <= pending_samples[0].fl;
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{red: red, green: green, blue: blue, end_of_row: end_of_row,
              end_of_frame: end_of_frame};
      if (rgb_expected.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, got);
        errors++;
      end else begin
        want = rgb_expected.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bayer_demosaic_5x5 verification failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) cfg_w_shadow = value[9:0];
    else cfg_h_shadow = value[11:0];
  endtask

  task automatic configure(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    @(posedge clk);
  endtask

  // checker pattern of extremes or random content, optional ignored flushes mid-frame
  task automatic push_frame(bit extremes, int noise_pct);
    int w, h;
    sample_t s;
    w = sat_width(cfg_w_shadow);
    h = sat_height(cfg_h_shadow);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (r + c > 0 && $urandom_range(99) < noise_pct) begin
          s.pix = 8'($urandom_range(255));
          s.fl = 1'b1;
          pending_samples.push_back(s);
        end
        s.pix = extremes ? (((r / 2 + c) % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
        s.fl = 1'b0;
        pending_samples.push_back(s);
      end
    for (int i = 0; i < 2 * w; i++) begin
      s.pix = 8'($urandom_range(255));
      s.fl = ($urandom_range(99) >= 15);
      pending_samples.push_back(s);
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_valid) @(posedge clk);
    while (rgb_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sample_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero width and height saturate to the minimum
    configure(12'd0, 12'd0);
    s.pix = 8'h5A;
    s.fl = 1'b1;
    pending_samples.push_back(s);
    push_frame(1'b1, 8);
    wait_idle();

    send_idle_pct = 78;
    configure(12'd6, 12'd5);
    push_frame(1'b0, 8);
    wait_idle();

    // receiver stalls heavily first, then both sides idle lightly
    send_idle_pct = 0;
    recv_stall_pct = 78;
    configure(12'd4, 12'd6);
    push_frame(1'b0, 5);
    while (pending_samples.size() > 20) @(posedge clk);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    wait_idle();

    if (errors == 0) $display("bayer_demosaic_5x5 verification clean");
    else $display("bayer_demosaic_5x5 verification failed");
    $finish;
  end
endmodule

/* files.f */
design/bdm_pkg.sv
design/bdm_line_mem.sv
design/bdm_cell.sv
design/bdm_kernel.sv
design/bdm_out_fifo.sv
design/bayer_demosaic_5x5.sv
design/bdm_checker.sv
test/bayer_demosaic_5x5_test.sv
